/* hw/rtl/isqrt_pkg.sv */
// isqrt_pkg: shared constants for the integer square root pipeline
// no dependencies; used by isqrt_cell and integer_square_root_top
package isqrt_pkg;

    // width of the operand field on the input channel
    localparam int VALUE_BITS = 32;

    // width of the root field on the output channel
    localparam int ROOT_BITS = 16;

    // default operand width, top bit is the sign bit
    localparam int OPERAND_BITS_DEFAULT = 32;

    // number of root bits a pipeline of the given operand width produces
    function automatic int root_stages(input int operand_bits);
        return (operand_bits + 1) / 2;
    endfunction

endpackage

/* hw/rtl/isqrt_cell.sv */
// isqrt_cell: one stage of the restoring square root chain, settles one root bit
// depends on isqrt_pkg for the default stage count
module isqrt_cell #(
    parameter int STAGES = isqrt_pkg::root_stages(isqrt_pkg::OPERAND_BITS_DEFAULT)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // upstream side
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [2*STAGES-1:0]   up_operand,
    input  logic [STAGES+1:0]     up_rem,
    input  logic [STAGES-1:0]     up_root,
    // downstream side
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output logic [2*STAGES-1:0]   dn_operand,
    output logic [STAGES+1:0]     dn_rem,
    output logic [STAGES-1:0]     dn_root
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [2*STAGES-1:0]   operand_reg;
    logic [STAGES+1:0]     rem_reg;
    logic [STAGES-1:0]     root_reg;

    logic [STAGES+1:0]     rem_shift;
    logic [STAGES+1:0]     trial;
    logic                  take;
    logic [STAGES+1:0]     rem_new;
    logic [STAGES-1:0]     root_new;
    logic [2*STAGES-1:0]   operand_new;
    logic                  load;

    // bring down the next two operand bits and try the next root bit
    always_comb
    begin
        rem_shift   = {up_rem[STAGES-1:0], up_operand[2*STAGES-1 -: 2]};
        trial       = {up_root, 2'b01};
        take        = (rem_shift >= trial);
        rem_new     = take ? (rem_shift - trial) : rem_shift;
        root_new    = {up_root[STAGES-2:0], take};
        operand_new = {up_operand[2*STAGES-3:0], 2'b00};
    end

    // stage moves when empty or when the neighbor takes its item
    assign up_ready   = !valid_reg || dn_ready;
    assign load       = up_valid && up_ready;
    assign valid_next = load ? 1'b1 : (dn_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload carries no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            operand_reg <= operand_new;
            rem_reg     <= rem_new;
            root_reg    <= root_new;
        end
    end

    assign dn_valid   = valid_reg;
    assign dn_operand = operand_reg;
    assign dn_rem     = rem_reg;
    assign dn_root    = root_reg;

`ifndef NO_ASSERTIONS
    // partial remainder never exceeds twice the partial root
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (rem_reg <= {1'b0, root_reg, 1'b0}))
        else $error("isqrt_cell: remainder out of range");

    // a held item keeps its root while the neighbor is not ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !dn_ready) |=> (valid_reg && $stable(root_reg) && $stable(rem_reg)))
        else $error("isqrt_cell: held item changed");

    // stage drains when its item leaves and nothing follows
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && dn_ready && !up_valid) |=> !valid_reg)
        else $error("isqrt_cell: item repeated");
`endif

endmodule

/* hw/rtl/integer_square_root_top.sv */
// Integer square root pipeline: floor(sqrt(value)) of a signed operand, zero when negative.
// One item enters per cycle while value_stall is low and passes through one registered cell
// per root bit, since each cell of the chain settles one root bit per item. Throughput is one
// item per cycle while root_stall is low; a stall holds the chain from the output back, and
// empty cells still take items. Only the low OPERAND_BITS bits of value are used, the root
// field carries the low 16 bits of the root.
// depends on isqrt_pkg and isqrt_cell
module integer_square_root_top #(
    parameter int OPERAND_BITS = isqrt_pkg::OPERAND_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              value_valid,
    output logic                              value_stall,
    input  logic signed [isqrt_pkg::VALUE_BITS-1:0] value,
    output logic                              root_valid,
    input  logic                              root_stall,
    output logic [isqrt_pkg::ROOT_BITS-1:0]   root
);

    localparam int STAGES = isqrt_pkg::root_stages(OPERAND_BITS);
    localparam int WIDE   = 2 * STAGES;

    logic [OPERAND_BITS+isqrt_pkg::VALUE_BITS-1:0] value_ext;
    logic [OPERAND_BITS-1:0]                       opnd;
    logic [OPERAND_BITS:0]                         opnd_ext;
    logic [WIDE-1:0]                               magnitude;
    logic                                          negative;

    logic                  cell_valid   [STAGES+1];
    logic                  cell_ready   [STAGES+1];
    logic [WIDE-1:0]       cell_operand [STAGES+1];
    logic [STAGES+1:0]     cell_rem     [STAGES+1];
    logic [STAGES-1:0]     cell_root    [STAGES+1];

    logic [STAGES+isqrt_pkg::ROOT_BITS-1:0]        root_ext;

    // take the low operand bits, negative operands enter as zero
    always_comb
    begin
        value_ext = {{OPERAND_BITS{1'b0}}, value};
        opnd      = value_ext[OPERAND_BITS-1:0];
        negative  = opnd[OPERAND_BITS-1];
        opnd_ext  = {1'b0, opnd};
        magnitude = negative ? '0 : opnd_ext[WIDE-1:0];
    end

    // head of the chain
    assign cell_valid[0]   = value_valid;
    assign cell_operand[0] = magnitude;
    assign cell_rem[0]     = '0;
    assign cell_root[0]    = '0;
    assign value_stall     = !cell_ready[0];

    // one cell per root bit
    for (genvar k = 0; k < STAGES; k++)
    begin : g_cell
        isqrt_cell #(
            .STAGES (STAGES)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (cell_valid[k]),
            .up_ready   (cell_ready[k]),
            .up_operand (cell_operand[k]),
            .up_rem     (cell_rem[k]),
            .up_root    (cell_root[k]),
            .dn_valid   (cell_valid[k+1]),
            .dn_ready   (cell_ready[k+1]),
            .dn_operand (cell_operand[k+1]),
            .dn_rem     (cell_rem[k+1]),
            .dn_root    (cell_root[k+1])
        );
    end

    // last cell is the output register
    assign cell_ready[STAGES] = !root_stall;
    assign root_valid         = cell_valid[STAGES];
    assign root_ext           = {{isqrt_pkg::ROOT_BITS{1'b0}}, cell_root[STAGES]};
    assign root               = root_ext[isqrt_pkg::ROOT_BITS-1:0];

`ifndef NO_ASSERTIONS
    // an accepted item lands in the first cell
    assert property (@(posedge clk) disable iff (!rst_n)
        (value_valid && !value_stall) |=> cell_valid[1])
        else $error("integer_square_root_top: item lost at entry");

    // the input is held back only while the chain is full up to the output
    assert property (@(posedge clk) disable iff (!rst_n)
        value_stall |-> (root_valid && root_stall))
        else $error("integer_square_root_top: needless stall");

    // a zero root in the last cell always shows as a zero root on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (root_valid && (cell_rem[STAGES] == '0) && (cell_root[STAGES] == '0)) |->
        (root == '0))
        else $error("integer_square_root_top: root mismatch");
`endif

endmodule

/* bench/tb_integer_square_root_top.sv */
// tb_integer_square_root_top: self-checking bench for the integer square root pipeline
// directed table then random operands, each root checked against a typed table value or a bit-serial predictor
// depends on isqrt_pkg and integer_square_root_top
module tb_integer_square_root_top;

    localparam int OPERAND_W     = isqrt_pkg::OPERAND_BITS_DEFAULT;
    localparam int RANDOM_ITEMS  = 1330;
    localparam int DRAIN_CYCLES  = 3 * ((OPERAND_W + 1) / 2) + 8;
    localparam int IDLE_LIMIT    = 2000;
    localparam int TABLE_ROWS    = 22;

    typedef struct {
        logic signed [isqrt_pkg::VALUE_BITS-1:0] operand;
        bit                                      typed;
        logic [isqrt_pkg::ROOT_BITS-1:0]         root_exp;
    } sqrt_case_t;

    logic                                    clk;
    logic                                    rst_n       = 1'b0;
    logic                                    value_valid = 1'b0;
    logic                                    value_stall;
    logic signed [isqrt_pkg::VALUE_BITS-1:0] value       = '0;
    logic                                    root_valid;
    logic                                    root_stall  = 1'b0;
    logic [isqrt_pkg::ROOT_BITS-1:0]         root;

    logic [isqrt_pkg::ROOT_BITS-1:0] expected_roots[$];
    sqrt_case_t                      directed_cases[TABLE_ROWS];
    int                              mismatches  = 0;
    int                              idle_cycles = 0;

    integer_square_root_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .value_valid(value_valid),
        .value_stall(value_stall),
        .value      (value),
        .root_valid (root_valid),
        .root_stall (root_stall),
        .root       (root)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // floor of the square root, two operand bits per step, zero when negative
    function automatic logic [isqrt_pkg::ROOT_BITS-1:0] isqrt_floor(
        input logic signed [isqrt_pkg::VALUE_BITS-1:0] operand);
        logic [63:0] rem;
        logic [63:0] acc;
        logic [63:0] place;
        rem = 64'(operand) & ({64{1'b1}} >> (64 - OPERAND_W));
        acc = '0;
        if (rem[OPERAND_W-1])
            return '0;
        place = 64'h4000_0000_0000_0000;
        while (place > rem)
            place = place >> 2;
        while (place != 0)
        begin
            if (rem >= acc + place)
            begin
                rem = rem - (acc + place);
                acc = (acc >> 1) + place;
            end
            else
                acc = acc >> 1;
            place = place >> 2;
        end
        return acc[isqrt_pkg::ROOT_BITS-1:0];
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_length(input bit calm);
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else if (pick < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // random operand: full range, negatives, around perfect squares, small values, right-shifted values
    function automatic logic signed [isqrt_pkg::VALUE_BITS-1:0] pick_operand();
        int          kind;
        logic [31:0] side;
        kind = $urandom_range(0, 9);
        side = $urandom_range(0, 46340);
        if (kind < 3)
            return $urandom;
        else if (kind < 5)
            return $urandom | 32'h8000_0000;
        else if (kind < 8)
            return side * side + $urandom_range(0, 2) - 1;
        else if (kind < 9)
            return $urandom_range(0, 1023);
        else
            return $urandom >> $urandom_range(1, 31);
    endfunction

    // present one item and hold it until taken
    task automatic drive_operand(input logic signed [isqrt_pkg::VALUE_BITS-1:0] operand,
                                 input logic [isqrt_pkg::ROOT_BITS-1:0] root_due,
                                 input int gap);
        if (gap > 0)
        begin
            value_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        value_valid <= 1'b1;
        value       <= operand;
        do
            @(posedge clk);
        while (value_stall);
        expected_roots.push_back(root_due);
    endtask

    // output stall, with calm stretches
    initial
    begin
        int hold;
        int span;
        bit calm;
        hold = 0;
        span = 0;
        calm = 1'b0;
        forever
        begin
            @(posedge clk);
            if (span == 0)
            begin
                span = 400;
                calm = ($urandom_range(0, 3) == 0);
            end
            span = span - 1;
            if (hold > 0)
            begin
                root_stall <= 1'b1;
                hold = hold - 1;
            end
            else
            begin
                hold = idle_length(calm);
                root_stall <= (hold > 0);
                if (hold > 0)
                    hold = hold - 1;
            end
        end
    end

    // compare each root taken against the oldest expectation
    always @(posedge clk)
    begin
        logic [isqrt_pkg::ROOT_BITS-1:0] want;
        if (rst_n && root_valid && !root_stall)
        begin
            if (expected_roots.size() == 0)
            begin
                mismatches = mismatches + 1;
                $display("%0t: unexpected root item, expected none, actual %0d", $time, root);
            end
            else
            begin
                want = expected_roots.pop_front();
                if (root !== want)
                begin
                    mismatches = mismatches + 1;
                    $display("%0t: root mismatch, expected %0d, actual %0d",
                             $time, want, root);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((value_valid && !value_stall) || (root_valid && !root_stall))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("integer_square_root_top verification failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int                                      i;
        bit                                      calm;
        logic signed [isqrt_pkg::VALUE_BITS-1:0] operand;
        logic [isqrt_pkg::ROOT_BITS-1:0]         due;

        // directed rows: extremes, small values, perfect squares and their neighbors
        directed_cases = '{
            '{32'sd0,            1'b1, 16'd0},
            '{32'sd1,            1'b1, 16'd1},
            '{32'sd2,            1'b0, 16'd0},
            '{32'sd3,            1'b0, 16'd0},
            '{32'sd4,            1'b1, 16'd2},
            '{32'sd9,            1'b1, 16'd3},
            '{32'sd15,           1'b0, 16'd0},
            '{32'sd16,           1'b1, 16'd4},
            '{32'sd24,           1'b0, 16'd0},
            '{32'sd25,           1'b1, 16'd5},
            '{32'sh7FFF_FFFF,    1'b1, 16'd46340},
            '{32'sh8000_0000,    1'b1, 16'd0},
            '{-32'sd1,           1'b1, 16'd0},
            '{32'shAAAA_AAAA,    1'b1, 16'd0},
            '{32'sh5555_5555,    1'b0, 16'd0},
            '{32'sd2147395600,   1'b1, 16'd46340},
            '{32'sd2147395599,   1'b0, 16'd0},
            '{32'sh4000_0000,    1'b1, 16'd32768},
            '{32'sh3FFF_FFFF,    1'b0, 16'd0},
            '{32'sd65536,        1'b1, 16'd256},
            '{32'sd65535,        1'b0, 16'd0},
            '{32'sd12345678,     1'b0, 16'd0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        for (i = 0; i < TABLE_ROWS; i++)
        begin
            operand = directed_cases[i].operand;
            due = directed_cases[i].typed ? directed_cases[i].root_exp : isqrt_floor(operand);
            drive_operand(operand, due, idle_length(1'b0));
        end

        // random part, with one full drain halfway through
        calm = 1'b0;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_ITEMS / 2)
            begin
                value_valid <= 1'b0;
                do
                    @(posedge clk);
                while (expected_roots.size() != 0);
            end
            operand = pick_operand();
            drive_operand(operand, isqrt_floor(operand), idle_length(calm));
        end
        value_valid <= 1'b0;

        // drain, then let the pipeline settle
        do
            @(posedge clk);
        while (expected_roots.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("integer_square_root_top verification clean");
        else
            $display("integer_square_root_top verification failed");
        $finish;
    end

endmodule
